FILE: design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg - shared types and codes of the first-fit page run allocator
// Run record, chain control bundle, mode, status and chain operation codes.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int MAX_RUNS = 64;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 16;
  localparam int LEN_W    = 17;

  localparam logic [LEN_W-1:0] LEN_MAX    = '1;
  localparam logic [LEN_W-1:0] HEAP_LIMIT = LEN_W'(1) << IDX_W;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] STS_DONE   = 2'd0;
  localparam logic [1:0] STS_NOFIT  = 2'd1;
  localparam logic [1:0] STS_BADFREE = 2'd2;
  localparam logic [1:0] STS_FULL   = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SCAN = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
  } run_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             keep;
    logic [CNT_W-1:0] cnt;
  } chain_ctl_t;

endpackage

FILE: design/first_fit_page_run_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_top - first-fit page run allocator
// Free run table held in a chain of cells rotating through a head processor.
//
//   channel  ports                                         handshake
//   input    in_mode in_page_count in_page_index           start & !busy
//   result   out_status out_granted_index out_granted_pages out_valid strobe
//   config   cfg_wdata (heap_pages)                        cfg_we
//
// Alloc and free scan the N stored runs, the chain rotating once through the
// head; a free then inserts its merged run at the front unless the table is
// full (N = 0: no scan). Init, rejected and zero-run allocs answer from idle.
// Reset empties the table; run contents need no reset.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_top import ffpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [LEN_W-1:0] in_page_count,
  input  logic [IDX_W-1:0] in_page_index,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [IDX_W-1:0] out_granted_index,
  output logic [LEN_W-1:0] out_granted_pages,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  chain_ctl_t ctl;
  run_t       bus;
  run_t       runs [MAX_RUNS];

  ffpa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_mode           (in_mode),
    .in_page_count     (in_page_count),
    .in_page_index     (in_page_index),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .head_i            (runs[0]),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_pages (out_granted_pages),
    .ctl               (ctl),
    .bus_o             (bus)
  );

  for (genvar k = 0; k < MAX_RUNS; k++) begin : g_cell
    ffpa_cell u_cell (
      .clk     (clk),
      .pos     (POS_W'(k)),
      .ctl     (ctl),
      .left_i  ((k == 0) ? bus : runs[(k == 0) ? 0 : k-1]),
      .right_i ((k == MAX_RUNS-1) ? runs[k] : runs[(k == MAX_RUNS-1) ? k : k+1]),
      .bus_i   (bus),
      .run_o   (runs[k])
    );
  end

endmodule

FILE: design/ffpa_cell.sv
// ----------------------------------------------------------------------------
// ffpa_cell - one slot of the run table chain
// Holds one run; rotates towards the head, takes the write-back at the ring
// tail, shifts away from the head on front insertion, loads slot 0 on init.
// ----------------------------------------------------------------------------
module ffpa_cell import ffpa_pkg::*; (
  input  logic             clk,
  input  logic [POS_W-1:0] pos,
  input  chain_ctl_t       ctl,
  input  run_t             left_i,
  input  run_t             right_i,
  input  run_t             bus_i,
  output run_t             run_o
);

  run_t             run_r, run_nxt;
  logic [CNT_W-1:0] pos1;

  assign pos1 = {1'b0, pos} + CNT_W'(1);

  always_comb begin
    run_nxt = run_r;
    unique case (ctl.op)
      OP_SCAN: begin
        if (pos1 < ctl.cnt) begin
          run_nxt = right_i;
        end else if (pos1 == ctl.cnt && ctl.keep) begin
          run_nxt = bus_i;
        end
      end
      OP_INS:  run_nxt = left_i;
      OP_LOAD: begin
        if (pos == '0) begin
          run_nxt = bus_i;
        end
      end
      default: run_nxt = run_r;
    endcase
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign run_o = run_r;

endmodule

FILE: design/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl - sequencer and head processor
// Accepts transactions, walks the chain head once per stored run, applies
// first-fit or merge rules, and issues one result per transaction.
// ----------------------------------------------------------------------------
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_mode,
  input  logic [LEN_W-1:0] in_page_count,
  input  logic [IDX_W-1:0] in_page_index,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  run_t             head_i,
  output logic             busy,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [IDX_W-1:0] out_granted_index,
  output logic [LEN_W-1:0] out_granted_pages,
  output chain_ctl_t       ctl,
  output run_t             bus_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [CNT_W-1:0] step_r, step_nxt, cnt_r, cnt_nxt;
  logic             free_r, free_nxt, found_r, found_nxt, any_r, any_nxt;
  logic [LEN_W-1:0] count_r, count_nxt, ml_r, ml_nxt, heap_r;
  logic [IDX_W-1:0] ms_r, ms_nxt, gidx_r, gidx_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [IDX_W-1:0] ogi_r, ogi_nxt;
  logic [LEN_W-1:0] ogp_r, ogp_nxt;

  logic [LEN_W-1:0] hp;
  logic [LEN_W:0]   free_end, merge_end, head_end, len_sum;
  logic [LEN_W-1:0] ml_sat;

  assign hp        = (heap_r > HEAP_LIMIT) ? HEAP_LIMIT : heap_r;
  assign free_end  = {2'b0, in_page_index} + {1'b0, in_page_count};
  assign merge_end = {2'b0, ms_r} + {1'b0, ml_r};
  assign head_end  = {2'b0, head_i.start} + {1'b0, head_i.len};
  assign len_sum   = {1'b0, ml_r} + {1'b0, head_i.len};
  assign ml_sat    = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    free_nxt  = free_r;
    found_nxt = found_r;
    any_nxt   = any_r;
    count_nxt = count_r;
    ms_nxt    = ms_r;
    ml_nxt    = ml_r;
    gidx_nxt  = gidx_r;
    ov_nxt    = 1'b0;
    os_nxt    = STS_DONE;
    ogi_nxt   = '0;
    ogp_nxt   = '0;
    ctl       = '{op: OP_HOLD, keep: 1'b0, cnt: cnt_r};
    bus_o     = head_i;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          free_nxt  = (in_mode == MODE_FREE);
          found_nxt = 1'b0;
          any_nxt   = 1'b0;
          count_nxt = in_page_count;
          ms_nxt    = in_page_index;
          ml_nxt    = in_page_count;
          gidx_nxt  = '0;
          step_nxt  = cnt_r;
          unique case (in_mode)
            MODE_INIT: begin
              ctl.op  = OP_LOAD;
              bus_o   = '{start: '0, len: hp};
              cnt_nxt = (hp != '0) ? CNT_W'(1) : '0;
              ov_nxt  = 1'b1;
            end
            MODE_ALLOC: begin
              if (in_page_count == '0 || cnt_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = STS_NOFIT;
              end else begin
                st_nxt = S_SCAN;
              end
            end
            MODE_FREE: begin
              if (in_page_count == '0 || free_end > {1'b0, hp}) begin
                ov_nxt = 1'b1;
                os_nxt = STS_BADFREE;
              end else if (cnt_r == '0) begin
                st_nxt = S_INS;
              end else begin
                st_nxt = S_SCAN;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = STS_BADFREE;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.op   = OP_SCAN;
        ctl.keep = 1'b1;
        step_nxt = step_r - CNT_W'(1);
        if (!free_r) begin
          if (!found_r && head_i.len > count_r) begin
            found_nxt   = 1'b1;
            gidx_nxt    = head_i.start;
            bus_o.start = head_i.start + count_r[IDX_W-1:0];
            bus_o.len   = head_i.len - count_r;
          end else if (!found_r && head_i.len == count_r) begin
            found_nxt = 1'b1;
            gidx_nxt  = head_i.start;
            ctl.keep  = 1'b0;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end else begin
          if (merge_end == {2'b0, head_i.start}) begin
            ml_nxt   = ml_sat;
            any_nxt  = 1'b1;
            ctl.keep = 1'b0;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end else if (head_end == {2'b0, ms_r}) begin
            ms_nxt   = head_i.start;
            ml_nxt   = ml_sat;
            any_nxt  = 1'b1;
            ctl.keep = 1'b0;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        if (step_r == CNT_W'(1)) begin
          if (!free_r) begin
            st_nxt  = S_IDLE;
            ov_nxt  = 1'b1;
            os_nxt  = found_nxt ? STS_DONE : STS_NOFIT;
            ogi_nxt = found_nxt ? gidx_nxt : '0;
            ogp_nxt = found_nxt ? count_r : '0;
          end else if (!any_nxt && cnt_r == CNT_W'(MAX_RUNS)) begin
            st_nxt = S_IDLE;
            ov_nxt = 1'b1;
            os_nxt = STS_FULL;
          end else begin
            st_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        ctl.op  = OP_INS;
        bus_o   = '{start: ms_r, len: ml_r};
        cnt_nxt = cnt_r + CNT_W'(1);
        st_nxt  = S_IDLE;
        ov_nxt  = 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      heap_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      if (cfg_we) begin
        heap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    free_r  <= free_nxt;
    found_r <= found_nxt;
    any_r   <= any_nxt;
    count_r <= count_nxt;
    ms_r    <= ms_nxt;
    ml_r    <= ml_nxt;
    gidx_r  <= gidx_nxt;
    os_r    <= os_nxt;
    ogi_r   <= ogi_nxt;
    ogp_r   <= ogp_nxt;
  end

  assign busy              = (st_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_granted_index = ogi_r;
  assign out_granted_pages = ogp_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RUNS))
    else $error("run count exceeds table size");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> (step_r != '0))
    else $error("scan running with no steps left");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_DONE) |->
      (out_granted_index == '0 && out_granted_pages == '0))
    else $error("failed transaction reports a grant");

endmodule
